[hw/rtl/assert_macros.svh]
// Assertion macros shared by the quaternion to Euler angle RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define Q2E_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("q2e assertion failed");
`define Q2E_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("q2e assertion failed");
`else
`define Q2E_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define Q2E_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/q2e_pkg.sv]
// Package: widths, constants, types and helper functions for the q2e pipeline
`timescale 1ns / 1ps
package q2e_pkg;
    localparam int QW            = 16;   // quaternion component, Q2.14
    localparam int AW            = 16;   // roll/yaw, Q3.13
    localparam int PW            = 15;   // pitch, Q2.13
    localparam int ACC_W         = 35;   // Q5.30 saturating sums
    localparam int PROD_W        = 2 * QW;
    localparam int SUM_W         = 37;
    localparam int XY_W          = 40;   // CORDIC vector, covers gain and quarter turn
    localparam int Z_W           = 34;   // CORDIC angle, Q30 radians
    localparam int CORDIC_STAGES = 16;
    localparam int SQ_STAGES     = 31;   // one result bit per stage
    localparam int SQ_W          = 62;
    localparam int ROOT_W        = 31;
    localparam int ANG_SHIFT     = 17;   // Q30 -> Q13

    localparam logic signed [Z_W-1:0]   HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ACC_W-1:0] ONE_Q30     = 35'sd1073741824;
    localparam logic signed [PW-1:0]    PITCH_LIM   = 15'sd12868;

    typedef struct packed {
        logic signed [ACC_W-1:0] sinr;
        logic signed [ACC_W-1:0] cosr;
        logic signed [ACC_W-1:0] sinp;
        logic signed [ACC_W-1:0] siny;
        logic signed [ACC_W-1:0] cosy;
    } t_terms;

    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        case (i)
            0:  atan_q30 = 34'sd843314857;
            1:  atan_q30 = 34'sd497837829;
            2:  atan_q30 = 34'sd263043837;
            3:  atan_q30 = 34'sd133525159;
            4:  atan_q30 = 34'sd67021687;
            5:  atan_q30 = 34'sd33543516;
            6:  atan_q30 = 34'sd16775851;
            7:  atan_q30 = 34'sd8388437;
            8:  atan_q30 = 34'sd4194283;
            9:  atan_q30 = 34'sd2097149;
            default: atan_q30 = (i < 31) ? (Z_W'(1) <<< (30 - i)) : '0;
        endcase
    endfunction

    // round half up to Q13, result still wide for saturation
    function automatic logic signed [Z_W-ANG_SHIFT:0] round_q13(
        input logic signed [Z_W-1:0] z);
        logic signed [Z_W:0] t;
        t = (Z_W+1)'(z) + (Z_W+1)'(36'sd65536);
        round_q13 = (Z_W-ANG_SHIFT+1)'(t >>> ANG_SHIFT);
    endfunction

    function automatic logic signed [AW-1:0] to_angle16(input logic signed [Z_W-1:0] z);
        logic signed [Z_W-ANG_SHIFT:0] q;
        q = round_q13(z);
        if (q > 18'sd32767)       to_angle16 = 16'sh7fff;
        else if (q < -18'sd32768) to_angle16 = 16'sh8000;
        else                      to_angle16 = q[AW-1:0];
    endfunction

    function automatic logic signed [PW-1:0] to_angle15(input logic signed [Z_W-1:0] z);
        logic signed [Z_W-ANG_SHIFT:0] q;
        q = round_q13(z);
        if (q > 18'sd16383)       to_angle15 = 15'sh3fff;
        else if (q < -18'sd16384) to_angle15 = 15'sh4000;
        else                      to_angle15 = q[PW-1:0];
    endfunction
endpackage

[hw/rtl/q2e_terms.sv]
// Products of quaternion components and saturated sine/cosine sums (2 stages)
`timescale 1ns / 1ps
module q2e_terms (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_ce,
    input  logic                            i_vld,
    input  logic signed [q2e_pkg::QW-1:0]   i_x,
    input  logic signed [q2e_pkg::QW-1:0]   i_y,
    input  logic signed [q2e_pkg::QW-1:0]   i_z,
    input  logic signed [q2e_pkg::QW-1:0]   i_w,
    output logic                            o_vld,
    output q2e_pkg::t_terms                 o_terms
);
    import q2e_pkg::*;

    logic signed [PROD_W-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    logic                     r_vld1, r_vld2;
    t_terms                   r_terms;
    t_terms                   n_terms;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        if (v > 37'sd17179869183)       sat_acc = 35'sh3_ffff_ffff;
        else if (v < -37'sd17179869184) sat_acc = 35'sh4_0000_0000;
        else                            sat_acc = v[ACC_W-1:0];
    endfunction

    // each product is Q28; doubled Q30 products gives the factor of 8
    function automatic logic signed [SUM_W-1:0] dbl_sum(input logic signed [PROD_W-1:0] a,
                                                        input logic signed [PROD_W-1:0] b,
                                                        input logic                     sub);
        logic signed [SUM_W-1:0] s;
        s = sub ? (SUM_W'(a) - SUM_W'(b)) : (SUM_W'(a) + SUM_W'(b));
        dbl_sum = s <<< 3;
    endfunction

    always_comb begin
        n_terms.sinr = sat_acc(dbl_sum(r_wx, r_yz, 1'b0));
        n_terms.cosr = sat_acc(SUM_W'(ONE_Q30) - dbl_sum(r_xx, r_yy, 1'b0));
        n_terms.sinp = sat_acc(dbl_sum(r_wy, r_zx, 1'b1));
        n_terms.siny = sat_acc(dbl_sum(r_wz, r_xy, 1'b0));
        n_terms.cosy = sat_acc(SUM_W'(ONE_Q30) - dbl_sum(r_yy, r_zz, 1'b0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_ce) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_wx    <= i_w * i_x;
            r_yz    <= i_y * i_z;
            r_xx    <= i_x * i_x;
            r_yy    <= i_y * i_y;
            r_wy    <= i_w * i_y;
            r_zx    <= i_z * i_x;
            r_wz    <= i_w * i_z;
            r_xy    <= i_x * i_y;
            r_zz    <= i_z * i_z;
            r_terms <= n_terms;
        end
    end

    assign o_vld   = r_vld2;
    assign o_terms = r_terms;
endmodule

[hw/rtl/q2e_sqrt.sv]
// Pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module q2e_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_ce,
    input  logic                            i_vld,
    input  logic [q2e_pkg::SQ_W-1:0]        i_v,
    output logic                            o_vld,
    output logic [q2e_pkg::ROOT_W-1:0]      o_root
);
    import q2e_pkg::*;

    logic [SQ_W-1:0] r_v   [SQ_STAGES];
    logic [SQ_W-1:0] r_r   [SQ_STAGES];
    logic            r_vld [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic [SQ_W-1:0] src_v, src_r, bitc, trial;
        logic            src_vld;
        if (k == 0) begin : g_first
            assign src_v   = i_v;
            assign src_r   = '0;
            assign src_vld = i_vld;
        end else begin : g_next
            assign src_v   = r_v[k-1];
            assign src_r   = r_r[k-1];
            assign src_vld = r_vld[k-1];
        end
        assign bitc  = SQ_W'(1) << (2 * (SQ_STAGES - 1 - k));
        assign trial = src_r + bitc;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (src_v >= trial) begin
                    r_v[k] <= src_v - trial;
                    r_r[k] <= (src_r >> 1) + bitc;
                end else begin
                    r_v[k] <= src_v;
                    r_r[k] <= src_r >> 1;
                end
            end
        end
    end

    assign o_vld  = r_vld[SQ_STAGES-1];
    assign o_root = r_r[SQ_STAGES-1][ROOT_W-1:0];
endmodule

[hw/rtl/q2e_cordic.sv]
// Pipelined vectoring CORDIC: four-quadrant arctangent in Q30 radians
`timescale 1ns / 1ps
module q2e_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_ce,
    input  logic                              i_vld,
    input  logic signed [q2e_pkg::ACC_W-1:0]  i_y,
    input  logic signed [q2e_pkg::ACC_W-1:0]  i_x,
    output logic                              o_vld,
    output logic signed [q2e_pkg::Z_W-1:0]    o_angle
);
    import q2e_pkg::*;

    logic signed [XY_W-1:0] r_x    [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] r_y    [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  r_z    [CORDIC_STAGES+1];
    logic                   r_zero [CORDIC_STAGES+1];
    logic                   r_vld  [CORDIC_STAGES+1];

    logic signed [XY_W-1:0] ex, ey;
    assign ex = XY_W'(i_x);
    assign ey = XY_W'(i_y);

    // quarter turn first when the cosine side is negative
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[ACC_W-1]) begin
                if (!i_y[ACC_W-1]) begin
                    r_x[0] <= ey;
                    r_y[0] <= -ex;
                    r_z[0] <= HALF_PI_Q30;
                end else begin
                    r_x[0] <= -ey;
                    r_y[0] <= ex;
                    r_z[0] <= -HALF_PI_Q30;
                end
            end else begin
                r_x[0] <= ex;
                r_y[0] <= ey;
                r_z[0] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= i_vld;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        logic signed [XY_W-1:0] dx, dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_ce) begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][XY_W-1]) begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + atan_q30(i);
                end else begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - atan_q30(i);
                end
            end
        end
    end

    assign o_vld   = r_vld[CORDIC_STAGES];
    assign o_angle = r_zero[CORDIC_STAGES] ? '0 : r_z[CORDIC_STAGES];
endmodule

[hw/rtl/quaternion_to_euler_zyx_top.sv]
// Top level: quaternion (Q2.14) to ZYX Euler angles (roll/yaw Q3.13, pitch Q2.13), fully pipelined
//
//  channel   dir  tdata fields (low bit first)                  tuser
//  s_axis    in   quat_x[15:0] quat_y quat_z quat_w (64 bits)    -
//  m_axis    out  roll_angle[15:0] pitch_angle[14:0] yaw (48b)   pitch_clamped
//
// One item per cycle while the pipeline is not held; the registered stages in order
// are products and sums, the square, the square root, the CORDIC and rounding.
// i_rst_n (synchronous) clears the valid bits only; the data registers are not reset.
// The whole pipeline advances together; it holds only when the output
// register carries an item that is not taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module quaternion_to_euler_zyx_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle, pad
    output logic [0:0]  m_axis_tuser    // pitch_clamped
);
    import q2e_pkg::*;

    typedef struct packed {
        t_terms terms;
        logic   clamped;
    } t_side;

    typedef struct packed {
        logic clamped;
        logic pos;
    } t_flag;

    logic ce;
    assign ce = !(m_axis_tvalid && !m_axis_tready);
    assign s_axis_tready = ce;

    // products and sums
    logic   t_vld;
    t_terms t_q;
    q2e_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (s_axis_tvalid),
        .i_x     (s_axis_tdata[15:0]),
        .i_y     (s_axis_tdata[31:16]),
        .i_z     (s_axis_tdata[47:32]),
        .i_w     (s_axis_tdata[63:48]),
        .o_vld   (t_vld),
        .o_terms (t_q)
    );

    // square stage: v = 1 - s^2 for the pitch cosine
    logic                    clamp_c;
    logic signed [ACC_W-1:0] abs_sinp;
    logic [29:0]             a_mag;
    logic [59:0]             a_sq;
    logic                    r_a_vld;
    logic [SQ_W-1:0]         r_a_v;
    t_side                   r_a_side;

    assign clamp_c  = (t_q.sinp >= ONE_Q30) || (t_q.sinp <= -ONE_Q30);
    assign abs_sinp = t_q.sinp[ACC_W-1] ? -t_q.sinp : t_q.sinp;
    assign a_mag    = abs_sinp[29:0];
    assign a_sq     = a_mag * a_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (ce) begin
            r_a_vld <= t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a_v            <= clamp_c ? '0 : ((SQ_W'(1) << 60) - SQ_W'(a_sq));
            r_a_side.terms   <= t_q;
            r_a_side.clamped <= clamp_c;
        end
    end

    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    q2e_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (r_a_vld),
        .i_v     (r_a_v),
        .o_vld   (sq_vld),
        .o_root  (sq_root)
    );

    // side data follows the square root
    t_side r_sd [SQ_STAGES];
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sd[0] <= r_a_side;
            for (int k = 1; k < SQ_STAGES; k++) r_sd[k] <= r_sd[k-1];
        end
    end
    t_side sd;
    assign sd = r_sd[SQ_STAGES-1];

    logic                  roll_vld, pitch_vld, yaw_vld;
    logic signed [Z_W-1:0] roll_z, pitch_z, yaw_z;

    q2e_cordic u_roll (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ce (ce), .i_vld (sq_vld),
        .i_y (sd.terms.sinr), .i_x (sd.terms.cosr),
        .o_vld (roll_vld), .o_angle (roll_z)
    );
    q2e_cordic u_pitch (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ce (ce), .i_vld (sq_vld),
        .i_y (sd.terms.sinp), .i_x ($signed({4'b0000, sq_root})),
        .o_vld (pitch_vld), .o_angle (pitch_z)
    );
    q2e_cordic u_yaw (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ce (ce), .i_vld (sq_vld),
        .i_y (sd.terms.siny), .i_x (sd.terms.cosy),
        .o_vld (yaw_vld), .o_angle (yaw_z)
    );

    t_flag r_fl [CORDIC_STAGES+1];
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_fl[0].clamped <= sd.clamped;
            r_fl[0].pos     <= !sd.terms.sinp[ACC_W-1];
            for (int k = 1; k <= CORDIC_STAGES; k++) r_fl[k] <= r_fl[k-1];
        end
    end
    t_flag fl;
    assign fl = r_fl[CORDIC_STAGES];

    // output register
    logic                   r_out_vld;
    logic signed [AW-1:0]   r_out_roll, r_out_yaw;
    logic signed [PW-1:0]   r_out_pitch;
    logic                   r_out_clamp;
    logic signed [Z_W-1:0]  pz;

    assign pz = fl.clamped ? (fl.pos ? HALF_PI_Q30 : -HALF_PI_Q30) : pitch_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_out_vld <= pitch_vld && roll_vld && yaw_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out_roll  <= to_angle16(roll_z);
            r_out_pitch <= to_angle15(pz);
            r_out_yaw   <= to_angle16(yaw_z);
            r_out_clamp <= fl.clamped;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = {1'b0, r_out_yaw, r_out_pitch, r_out_roll};
    assign m_axis_tuser[0] = r_out_clamp;

    `Q2E_ASSERT_IMP(a_stall_only_on_output, i_clk, i_rst_n, !s_axis_tready, r_out_vld)
    `Q2E_ASSERT_IMP(a_clamp_quarter_turn, i_clk, i_rst_n, r_out_vld && r_out_clamp, (r_out_pitch == PITCH_LIM) || (r_out_pitch == -PITCH_LIM))
    `Q2E_ASSERT_IMP(a_pitch_range, i_clk, i_rst_n, r_out_vld, (r_out_pitch <= PITCH_LIM) && (r_out_pitch >= -PITCH_LIM))
    `Q2E_ASSERT_IMP(a_lanes_aligned, i_clk, i_rst_n, 1'b1, (roll_vld == pitch_vld) && (pitch_vld == yaw_vld))
endmodule

[test/quaternion_to_euler_zyx_top_test.sv]
// Stream testbench for the quaternion to ZYX Euler angle pipeline, with a bit-exact predictor
`timescale 1ns / 1ps
module quaternion_to_euler_zyx_top_test;
    import q2e_pkg::*;

    typedef struct packed {
        logic [15:0] roll;
        logic [14:0] pitch;
        logic [15:0] yaw;
        logic        clamp;
    } t_euler;

    localparam longint ONE_Q = 64'sd1073741824;
    localparam longint HPI_Q = 64'sd1686629713;
    localparam longint ACC_HI = (64'sd1 <<< 34) - 1;
    localparam longint ACC_LO = -(64'sd1 <<< 34);
    localparam longint ATAN_T [16] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    t_euler angles_due [$];
    int     err_cnt = 0;
    int     items_sent = 0;
    int     results_seen = 0;
    int     clamp_seen = 0;
    int     ready_pct = 100;
    int     hold_req = 0;
    int     hold_cnt = 0;

    quaternion_to_euler_zyx_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("timeout at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
    end

    // Q2.14 x Q2.14 -> Q30
    function automatic longint prod_q30(logic signed [15:0] a, logic signed [15:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p * 4;
    endfunction

    function automatic longint sat_sum(longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vec_atan2(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HPI_Q;
            end else begin
                x = -y; y = t; z = -HPI_Q;
            end
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ATAN_T[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_T[i];
            end
        end
        return z;
    endfunction

    // Q30 -> Q13, round half up, saturate to w bits
    function automatic longint q13_angle(longint z, int w);
        longint q, hi, lo;
        q = (z + 65536) >>> 17;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -(64'sd1 <<< (w - 1));
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        return q;
    endfunction

    function automatic t_euler euler_of(logic [63:0] d);
        logic signed [15:0] qx, qy, qz, qw;
        longint sinr, cosr, sinp, siny, cosy, pz, a;
        t_euler e;
        qx = d[15:0]; qy = d[31:16]; qz = d[47:32]; qw = d[63:48];
        sinr = sat_sum(2 * (prod_q30(qw, qx) + prod_q30(qy, qz)));
        cosr = sat_sum(ONE_Q - 2 * (prod_q30(qx, qx) + prod_q30(qy, qy)));
        sinp = sat_sum(2 * (prod_q30(qw, qy) - prod_q30(qz, qx)));
        siny = sat_sum(2 * (prod_q30(qw, qz) + prod_q30(qx, qy)));
        cosy = sat_sum(ONE_Q - 2 * (prod_q30(qy, qy) + prod_q30(qz, qz)));
        e.clamp = (sinp >= ONE_Q) || (sinp <= -ONE_Q);
        if (e.clamp) begin
            pz = (sinp > 0) ? HPI_Q : -HPI_Q;
        end else begin
            a = (sinp < 0) ? -sinp : sinp;
            pz = vec_atan2(sinp, int_sqrt((64'd1 << 60) - longint'(a * a)));
        end
        e.roll  = 16'(q13_angle(vec_atan2(sinr, cosr), 16));
        e.pitch = 15'(q13_angle(pz, 15));
        e.yaw   = 16'(q13_angle(vec_atan2(siny, cosy), 16));
        return e;
    endfunction

    // one item, driven on the falling edge, held until taken
    task automatic send_quat(logic [15:0] qx, qy, qz, qw, int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tdata = {qw, qz, qy, qx};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        angles_due.push_back(euler_of(s_axis_tdata));
        items_sent++;
    endtask

    task automatic idle_sender();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = ($urandom_range(0, 99) < ready_pct);
        end
    end

    always @(posedge i_clk) begin
        t_euler got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.roll = m_axis_tdata[15:0];
            got.pitch = m_axis_tdata[30:16];
            got.yaw = m_axis_tdata[46:31];
            got.clamp = m_axis_tuser[0];
            results_seen++;
            if (got.clamp) clamp_seen++;
            if (angles_due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                err_cnt++;
            end else begin
                want = angles_due.pop_front();
                if (got.roll !== want.roll) begin
                    $display("%0t: roll exp %h got %h", $time, want.roll, got.roll);
                    err_cnt++;
                end
                if (got.pitch !== want.pitch) begin
                    $display("%0t: pitch exp %h got %h", $time, want.pitch, got.pitch);
                    err_cnt++;
                end
                if (got.yaw !== want.yaw) begin
                    $display("%0t: yaw exp %h got %h", $time, want.yaw, got.yaw);
                    err_cnt++;
                end
                if (got.clamp !== want.clamp) begin
                    $display("%0t: clamp exp %b got %b", $time, want.clamp, got.clamp);
                    err_cnt++;
                end
            end
        end
    end

    task automatic test_directed();
        ready_pct = 100;
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 0);         // identity
        send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 0);         // negative cos terms
        send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 0);
        send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 0);
        send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 0);     // lock, positive
        send_quat(16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 1);    // lock, negative
        send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 0);     // near lock via -zx
        send_quat(16'sd8192, 16'sd8192, 16'sd0, 16'sd0, 0);       // roll args both zero
        send_quat(16'sd0, 16'sd8192, 16'sd8192, 16'sd0, 2);       // yaw args both zero
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0); // saturating sums
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
        send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
        send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 0);
        send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 0);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 0);
        send_quat(-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 0);        // -2.0
        send_quat(16'sd100, 16'sd11500, -16'sd50, 16'sd11600, 0); // near lock
        send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd16384, 0);
        send_quat(16'sd16384, 16'sd0, 16'sd1, 16'sd0, 0);         // cos < 0, sin tiny
        send_quat(16'sd16384, 16'sd0, -16'sd1, 16'sd0, 0);
        idle_sender();
    endtask

    task automatic burst_items(int n, int mode);
        int left, gap;
        logic [15:0] c [4];
        left = 0;
        for (int k = 0; k < n; k++) begin
            gap = 0;
            if (left == 0) begin
                left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            left--;
            for (int j = 0; j < 4; j++) begin
                if (mode == 1 || $urandom_range(0, 9) == 0)
                    c[j] = 16'($urandom());
                else
                    c[j] = 16'($signed($urandom_range(0, 32768)) - 16384);
            end
            // steer some items close to gimbal lock
            if (mode == 0 && $urandom_range(0, 9) == 0) begin
                c[3] = c[1] + 16'($urandom_range(0, 64)) - 16'd32;
                c[0] = 16'($signed($urandom_range(0, 400)) - 200);
                c[2] = 16'($signed($urandom_range(0, 400)) - 200);
            end
            send_quat(c[0], c[1], c[2], c[3], gap);
        end
        idle_sender();
    endtask

    task automatic test_random_range();
        ready_pct = 70;
        burst_items(600, 0);
        ready_pct = 100;
        burst_items(300, 0);
        ready_pct = 35;
        burst_items(300, 0);
    endtask

    task automatic test_random_full();
        ready_pct = 60;
        burst_items(300, 1);
    endtask

    task automatic test_backpressure();
        ready_pct = 90;
        @(negedge i_clk);
        hold_req = 300;
        for (int k = 0; k < 130; k++)
            send_quat(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()), 0);
        idle_sender();
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_range();
        test_random_full();
        test_backpressure();
        ready_pct = 80;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        $display("sent %0d quaternions, checked %0d angle sets (%0d at gimbal lock)",
                 items_sent, results_seen, clamp_seen);
        $display("covered unit and out-of-range inputs, saturation, stalls and a long hold-off");
        if (err_cnt == 0 && angles_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
